>>> rtl/core/tepp_pkg.sv
// Shared types and constants for the tracker event packet parser.
package tepp_pkg;

  // Largest hit count that is still parsed as an event.
  localparam int unsigned MaxHits     = 192;
  localparam int unsigned HeaderBytes = 17;
  localparam int unsigned EventBytes  = 12;

  localparam logic [4:0] HEADER_LAST   = 5'(HeaderBytes - 1);
  localparam logic [4:0] EVENT_LAST    = 5'(EventBytes - 1);
  localparam logic [7:0] MAX_HITS      = 8'(MaxHits);
  localparam logic [7:0] PAD_BYTE      = 8'hff;
  localparam logic [7:0] VER_RUN16     = 8'd5;
  localparam logic [7:0] VER_PAD       = 8'd4;

  // Record kinds as shown on the result channel.
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_EVENT  = 2'd1,
    KIND_HIT    = 2'd2,
    KIND_STATUS = 2'd3
  } kind_e;

  // End-of-packet status codes.
  typedef enum logic [15:0] {
    STATUS_OK    = 16'd0,
    STATUS_SHORT = 16'd1
  } status_e;

  // Parser sections, one-hot.
  typedef enum logic [4:0] {
    SEC_HEADER = 5'b00001,
    SEC_RUN    = 5'b00010,
    SEC_EVENT  = 5'b00100,
    SEC_HITS   = 5'b01000,
    SEC_DROP   = 5'b10000
  } section_e;

  // One header, event or hit record.
  typedef struct packed {
    kind_e        kind;
    logic [15:0]  word_a;
    logic [15:0]  word_b;
    logic [15:0]  word_c;
    logic [15:0]  word_d;
    logic [7:0]   small_a;
    logic [7:0]   small_b;
    logic [7:0]   format_version;
    logic [15:0]  run_number;
    logic [31:0]  event_number;
    logic [47:0]  time_value;
  } rec_t;

  // What one input item produces: an optional record and an optional status.
  typedef struct packed {
    logic    has_rec;
    rec_t    rec;
    logic    has_stat;
    status_e code;
  } result_t;

endpackage

>>> rtl/core/tepp_parser.sv
// Byte parser: section state, field registers and record formation.
module tepp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output tepp_pkg::result_t result_o
);
  import tepp_pkg::*;

  section_e    sec_q, sec_d;
  logic [4:0]  pos_q, pos_d;
  logic [63:0] hi_q, hi_d;
  logic [63:0] hct_q, hct_d;
  logic [7:0]  ver_q, ver_d;
  logic [15:0] run_q, run_d;
  logic [47:0] ei_q, ei_d;
  logic [47:0] et_q, et_d;
  logic [7:0]  hits_q, hits_d;
  logic [15:0] hp_q, hp_d;
  logic [7:0]  n_hits;
  logic [2:0]  time_lane;
  logic        boundary;
  result_t     res;

  function automatic logic [63:0] set_byte64(logic [63:0] w, logic [2:0] idx, logic [7:0] b);
    logic [63:0] r;
    r = w;
    for (int i = 0; i < 8; i++) begin
      if (idx == 3'(i)) r[i*8 +: 8] = b;
    end
    return r;
  endfunction

  function automatic logic [47:0] set_byte48(logic [47:0] w, logic [2:0] idx, logic [7:0] b);
    logic [47:0] r;
    r = w;
    for (int i = 0; i < 6; i++) begin
      if (idx == 3'(i)) r[i*8 +: 8] = b;
    end
    return r;
  endfunction

  assign time_lane = 3'(pos_q - 5'd6);

  // Next state and records for the byte in the input register.
  always_comb begin
    sec_d    = sec_q;
    pos_d    = pos_q;
    hi_d     = hi_q;
    hct_d    = hct_q;
    ver_d    = ver_q;
    run_d    = run_q;
    ei_d     = ei_q;
    et_d     = et_q;
    hits_d   = hits_q;
    hp_d     = hp_q;
    n_hits   = '0;
    boundary = 1'b0;
    res      = '0;
    res.code = STATUS_OK;
    unique case (sec_q)
      SEC_HEADER: begin
        if (pos_q < 5'd8) begin
          hi_d = set_byte64(hi_q, pos_q[2:0], byte_i);
        end else if (pos_q < 5'd16) begin
          hct_d = set_byte64(hct_q, pos_q[2:0], byte_i);
        end else begin
          ver_d = byte_i;
        end
        if (pos_q != HEADER_LAST) begin
          pos_d = pos_q + 5'd1;
        end else begin
          sec_d = SEC_RUN;
          pos_d = '0;
        end
      end
      SEC_RUN: begin
        if (pos_q == 5'd0) begin
          run_d = {8'h00, byte_i};
        end else begin
          run_d = {byte_i, run_q[7:0]};
        end
        if (pos_q == 5'd0 && ver_q >= VER_RUN16) begin
          pos_d = 5'd1;
        end else begin
          // Run number complete: the packet header record goes out.
          res.has_rec            = 1'b1;
          res.rec.kind           = KIND_HEADER;
          res.rec.word_a         = hi_q[15:0];
          res.rec.word_b         = hi_q[31:16];
          res.rec.word_c         = hi_q[63:48];
          res.rec.word_d         = hct_q[15:0];
          res.rec.small_a        = hi_q[39:32];
          res.rec.small_b        = hi_q[47:40];
          res.rec.format_version = ver_q;
          res.rec.run_number     = run_d;
          res.rec.time_value     = hct_q[63:16];
          sec_d    = SEC_EVENT;
          pos_d    = '0;
          boundary = 1'b1;
        end
      end
      SEC_EVENT: begin
        if (pos_q == 5'd0 && last_i && byte_i == PAD_BYTE && ver_q >= VER_PAD) begin
          // A lone trailing pad byte where an event would begin.
          boundary = 1'b1;
        end else begin
          if (pos_q < 5'd6) begin
            ei_d = set_byte48(ei_q, pos_q[2:0], byte_i);
          end else begin
            et_d = set_byte48(et_q, time_lane, byte_i);
          end
          if (pos_q != EVENT_LAST) begin
            pos_d = pos_q + 5'd1;
          end else begin
            pos_d  = '0;
            n_hits = ei_d[7:0];
            if (n_hits > MAX_HITS) begin
              sec_d = SEC_DROP;
            end else begin
              res.has_rec          = 1'b1;
              res.rec.kind         = KIND_EVENT;
              res.rec.word_a       = {8'h00, n_hits};
              res.rec.word_b       = {8'h00, ei_d[15:8]};
              res.rec.small_a      = hi_q[39:32];
              res.rec.event_number = ei_d[47:16];
              res.rec.time_value   = et_d;
              hits_d = n_hits;
              if (n_hits == 8'd0) begin
                boundary = 1'b1;
              end else begin
                sec_d = SEC_HITS;
              end
            end
          end
        end
      end
      SEC_HITS: begin
        if (pos_q == 5'd0) begin
          hp_d  = {8'h00, byte_i};
          pos_d = 5'd1;
        end else if (pos_q == 5'd1) begin
          hp_d  = {byte_i, hp_q[7:0]};
          pos_d = 5'd2;
        end else begin
          res.has_rec     = 1'b1;
          res.rec.kind    = KIND_HIT;
          res.rec.word_a  = {5'd0, byte_i[5:0], hp_q[15:11]};
          res.rec.word_b  = {11'd0, hp_q[4:0]};
          res.rec.word_c  = {13'd0, hp_q[7:5]};
          res.rec.word_d  = {13'd0, hp_q[10:8]};
          res.rec.small_a = {6'd0, byte_i[7:6]};
          pos_d  = '0;
          hits_d = hits_q - 8'd1;
          if (hits_d == 8'd0) begin
            sec_d    = SEC_EVENT;
            boundary = 1'b1;
          end
        end
      end
      SEC_DROP: begin
        // Bytes after an oversized event are discarded.
      end
      default: begin
        sec_d = SEC_HEADER;
        pos_d = '0;
      end
    endcase

    // The marked byte closes the packet with a status and restarts parsing.
    if (last_i) begin
      res.has_stat = 1'b1;
      if (sec_d == SEC_DROP || boundary) begin
        res.code = STATUS_OK;
      end else begin
        res.code = STATUS_SHORT;
      end
      sec_d = SEC_HEADER;
      pos_d = '0;
    end
  end

  assign result_o = res;

  // Parser state advances once per parsed item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q  <= SEC_HEADER;
      pos_q  <= '0;
      hi_q   <= '0;
      hct_q  <= '0;
      ver_q  <= '0;
      run_q  <= '0;
      ei_q   <= '0;
      et_q   <= '0;
      hits_q <= '0;
      hp_q   <= '0;
    end else if (fire_i) begin
      sec_q  <= sec_d;
      pos_q  <= pos_d;
      hi_q   <= hi_d;
      hct_q  <= hct_d;
      ver_q  <= ver_d;
      run_q  <= run_d;
      ei_q   <= ei_d;
      et_q   <= et_d;
      hits_q <= hits_d;
      hp_q   <= hp_d;
    end
  end

endmodule

>>> rtl/core/tepp_out_stage.sv
// Result register that presents a record and then its status, one item at a time.
module tepp_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  tepp_pkg::result_t  result_i,
  output logic               can_load_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tepp_pkg::rec_t     rec_o,
  output logic               last_o
);
  import tepp_pkg::*;

  logic    has_rec_q;
  logic    has_stat_q;
  rec_t    rec_q;
  status_e code_q;
  logic    pop;

  assign out_valid_o = has_rec_q | has_stat_q;
  assign pop         = out_valid_o & out_ready_i;
  // Free now, or emptied by the item that leaves this cycle.
  assign can_load_o  = !out_valid_o || (out_ready_i && !(has_rec_q && has_stat_q));

  // The record goes first; a status item follows it.
  always_comb begin
    if (has_rec_q) begin
      rec_o  = rec_q;
      last_o = 1'b0;
    end else begin
      rec_o        = '0;
      rec_o.kind   = KIND_STATUS;
      rec_o.word_a = code_q;
      last_o       = has_stat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_rec_q  <= 1'b0;
      has_stat_q <= 1'b0;
    end else if (load_i) begin
      has_rec_q  <= result_i.has_rec;
      has_stat_q <= result_i.has_stat;
    end else if (pop) begin
      if (has_rec_q) begin
        has_rec_q <= 1'b0;
      end else begin
        has_stat_q <= 1'b0;
      end
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rec_q  <= result_i.rec;
      code_q <= result_i.code;
    end
  end

endmodule

>>> rtl/core/tracker_event_packet_parser.sv
// Top level of the tracker event packet parser: input register, parser and result stage.
//
// The input channel takes one packet byte per item, with end_of_packet_i set on
// the last byte. The result channel gives header, event and hit records and,
// after the marked byte, one status record with last_of_packet_o set.
// Both channels use valid and ready.
//
// A byte accepted sits in the input register and is parsed there; its record
// is loaded into the result register as the parser takes the byte, and is shown
// from that register. One byte is taken every cycle while the receiver keeps
// up. A marked byte that yields both a record and a status holds the result
// register for both items, so the next byte waits until the record has left.
//
// When the receiver stalls, the result register holds its item and the input
// register fills; in_ready_o then drops until the result register frees.
// Reset clears both registers and starts the parser at the packet header.
module tracker_event_packet_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_packet_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  record_kind_o,
  output logic [15:0] word_a_o,
  output logic [15:0] word_b_o,
  output logic [15:0] word_c_o,
  output logic [15:0] word_d_o,
  output logic [7:0]  small_a_o,
  output logic [7:0]  small_b_o,
  output logic [7:0]  format_version_o,
  output logic [15:0] run_number_o,
  output logic [31:0] event_number_o,
  output logic [47:0] time_value_o,
  output logic        last_of_packet_o
);
  import tepp_pkg::*;

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       eop_q;
  logic       can_load;
  logic       fire;
  result_t    result;
  rec_t       rec;

  assign fire       = in_valid_q & can_load;
  assign in_ready_o = !in_valid_q || fire;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
      eop_q  <= end_of_packet_i;
    end
  end

  tepp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .byte_i   (byte_q),
    .last_i   (eop_q),
    .result_o (result)
  );

  tepp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .result_i    (result),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rec_o       (rec),
    .last_o      (last_of_packet_o)
  );

  assign record_kind_o    = rec.kind;
  assign word_a_o         = rec.word_a;
  assign word_b_o         = rec.word_b;
  assign word_c_o         = rec.word_c;
  assign word_d_o         = rec.word_d;
  assign small_a_o        = rec.small_a;
  assign small_b_o        = rec.small_b;
  assign format_version_o = rec.format_version;
  assign run_number_o     = rec.run_number;
  assign event_number_o   = rec.event_number;
  assign time_value_o     = rec.time_value;

endmodule

>>> rtl/core/tepp_checker.sv
// Port-level checks for the tracker event packet parser, bound to the top level.
module tepp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  record_kind_o,
  input logic [15:0] word_a_o,
  input logic [15:0] word_b_o,
  input logic [15:0] word_c_o,
  input logic [15:0] word_d_o,
  input logic [7:0]  small_a_o,
  input logic [7:0]  small_b_o,
  input logic [7:0]  format_version_o,
  input logic [15:0] run_number_o,
  input logic [31:0] event_number_o,
  input logic [47:0] time_value_o,
  input logic        last_of_packet_o
);
  import tepp_pkg::*;

  // A stalled result item keeps its kind.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(record_kind_o))
    else $error("result item changed while stalled");

  // Only the status item marks the end of a packet.
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((record_kind_o == KIND_STATUS) == last_of_packet_o))
    else $error("last_of_packet does not match status kind");

  // A status item carries only its code, ok or too short.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_packet_o |-> word_a_o[15:1] == 15'd0 &&
      word_b_o == 16'd0 && word_c_o == 16'd0 && word_d_o == 16'd0 &&
      small_a_o == 8'd0 && small_b_o == 8'd0 && format_version_o == 8'd0 &&
      run_number_o == 16'd0 && event_number_o == 32'd0 && time_value_o == 48'd0)
    else $error("bad status record");

  // Hit fields stay inside their bit widths.
  a_hit_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_kind_o == KIND_HIT |-> word_a_o[15:11] == 5'd0 &&
      word_b_o[15:5] == 11'd0 && word_c_o[15:3] == 13'd0 &&
      word_d_o[15:3] == 13'd0 && small_a_o[7:2] == 6'd0)
    else $error("hit record field out of range");

endmodule

bind tracker_event_packet_parser tepp_checker u_tepp_checker (.*);

>>> test/tb_top.sv
// Self-checking testbench for the tracker event packet parser.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tepp_pkg::*;

  // How a generated packet is finished off.
  typedef enum int {
    END_CLEAN,
    END_PAD,
    END_CUT
  } packet_end_e;

  // One packet byte waiting to be driven.
  typedef struct packed {
    logic [7:0] data;
    logic       eop;
  } byte_item_t;

  // One record as seen on the result channel.
  typedef struct packed {
    kind_e       kind;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [15:0] word_c;
    logic [15:0] word_d;
    logic [7:0]  small_a;
    logic [7:0]  small_b;
    logic [7:0]  format_version;
    logic [15:0] run_number;
    logic [31:0] event_number;
    logic [47:0] time_value;
    logic        last_of_packet;
  } record_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_packet = 1'b0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [1:0]  record_kind_o;
  logic [15:0] word_a_o;
  logic [15:0] word_b_o;
  logic [15:0] word_c_o;
  logic [15:0] word_d_o;
  logic [7:0]  small_a_o;
  logic [7:0]  small_b_o;
  logic [7:0]  format_version_o;
  logic [15:0] run_number_o;
  logic [31:0] event_number_o;
  logic [47:0] time_value_o;
  logic        last_of_packet_o;

  byte_item_t  pending_bytes[$];
  record_t     expected_records[$];
  int unsigned total_bytes = 0;
  int unsigned accepted_bytes = 0;
  int unsigned packet_count = 0;
  int unsigned kind_count[4];
  int unsigned errors = 0;

  // Parser state mirrored by the predictor.
  section_e    sec = SEC_HEADER;
  logic [4:0]  pos = '0;
  logic [63:0] hdr_ident = '0;
  logic [63:0] hdr_count_time = '0;
  logic [7:0]  hdr_version = '0;
  logic [15:0] run_word = '0;
  logic [47:0] ev_ident = '0;
  logic [47:0] ev_time = '0;
  logic [7:0]  hits_left = '0;
  logic [15:0] hit_partial = '0;

  tracker_event_packet_parser u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte),
    .end_of_packet_i  (end_of_packet),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .record_kind_o    (record_kind_o),
    .word_a_o         (word_a_o),
    .word_b_o         (word_b_o),
    .word_c_o         (word_c_o),
    .word_d_o         (word_d_o),
    .small_a_o        (small_a_o),
    .small_b_o        (small_b_o),
    .format_version_o (format_version_o),
    .run_number_o     (run_number_o),
    .event_number_o   (event_number_o),
    .time_value_o     (time_value_o),
    .last_of_packet_o (last_of_packet_o)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle percentages per phase: sender-light, receiver-light, then none.
  function automatic int unsigned idle_pct(input bit sender);
    int unsigned phase;
    phase = (total_bytes == 0) ? 0 : (accepted_bytes * 3) / total_bytes;
    if (phase == 0) return sender ? 32 : 67;
    if (phase == 1) return sender ? 67 : 32;
    return 0;
  endfunction

  // Works out the records that one accepted byte produces.
  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic       at_boundary;
    logic [7:0] n;
    logic [7:0] h0;
    logic [7:0] h1;
    int         idx;
    record_t    r;
    at_boundary = 1'b0;
    idx = int'(pos);
    r = '0;
    case (sec)
      SEC_RUN: begin
        if (pos == 5'd0) run_word = {8'h00, b};
        else run_word = {b, run_word[7:0]};
        if (pos == 5'd0 && hdr_version >= VER_RUN16) begin
          pos = 5'd1;
        end else begin
          r.kind = KIND_HEADER;
          r.word_a = hdr_ident[15:0];
          r.word_b = hdr_ident[31:16];
          r.word_c = hdr_ident[63:48];
          r.word_d = hdr_count_time[15:0];
          r.small_a = hdr_ident[39:32];
          r.small_b = hdr_ident[47:40];
          r.format_version = hdr_version;
          r.run_number = run_word;
          r.time_value = hdr_count_time[63:16];
          expected_records = {expected_records, r};
          sec = SEC_EVENT;
          pos = '0;
          at_boundary = 1'b1;
        end
      end
      SEC_EVENT: begin
        // A lone pad byte where an event would start closes the packet cleanly.
        if (pos == 5'd0 && last && b == PAD_BYTE && hdr_version >= VER_PAD) begin
          at_boundary = 1'b1;
        end else begin
          if (idx < 6) ev_ident[8*idx +: 8] = b;
          else ev_time[8*(idx-6) +: 8] = b;
          if (pos < EVENT_LAST) begin
            pos = pos + 5'd1;
          end else begin
            n = ev_ident[7:0];
            pos = '0;
            if (n > MAX_HITS) begin
              // Oversized event: drop the rest of the packet, status ok at its end.
              if (last) begin
                r.kind = KIND_STATUS;
                r.word_a = STATUS_OK;
                r.last_of_packet = 1'b1;
                expected_records = {expected_records, r};
                sec = SEC_HEADER;
              end else begin
                sec = SEC_DROP;
              end
              return;
            end
            r.kind = KIND_EVENT;
            r.word_a = {8'h00, n};
            r.word_b = {8'h00, ev_ident[15:8]};
            r.small_a = hdr_ident[39:32];
            r.event_number = ev_ident[47:16];
            r.time_value = ev_time;
            expected_records = {expected_records, r};
            hits_left = n;
            if (n == 8'd0) at_boundary = 1'b1;
            else sec = SEC_HITS;
          end
        end
      end
      SEC_HITS: begin
        if (pos == 5'd0) begin
          hit_partial = {8'h00, b};
          pos = 5'd1;
        end else if (pos == 5'd1) begin
          hit_partial = {b, hit_partial[7:0]};
          pos = 5'd2;
        end else begin
          h0 = hit_partial[7:0];
          h1 = hit_partial[15:8];
          r.kind = KIND_HIT;
          r.word_a = {5'd0, b[5:0], h1[7:3]};
          r.word_b = {11'd0, h0[4:0]};
          r.word_c = {13'd0, h0[7:5]};
          r.word_d = {13'd0, h1[2:0]};
          r.small_a = {6'd0, b[7:6]};
          expected_records = {expected_records, r};
          pos = '0;
          hits_left = hits_left - 8'd1;
          if (hits_left == 8'd0) begin
            sec = SEC_EVENT;
            at_boundary = 1'b1;
          end
        end
      end
      SEC_DROP: begin
      end
      default: begin
        if (idx < 8) hdr_ident[8*idx +: 8] = b;
        else if (idx < 16) hdr_count_time[8*(idx-8) +: 8] = b;
        else hdr_version = b;
        if (pos < HEADER_LAST) begin
          pos = pos + 5'd1;
        end else begin
          sec = SEC_RUN;
          pos = '0;
        end
      end
    endcase

    // The marked byte is followed by a status record, then a fresh packet.
    if (last) begin
      r = '0;
      r.kind = KIND_STATUS;
      r.word_a = (sec == SEC_DROP || at_boundary) ? STATUS_OK : STATUS_SHORT;
      r.last_of_packet = 1'b1;
      expected_records = {expected_records, r};
      sec = SEC_HEADER;
      pos = '0;
    end
  endtask

  // Picks a hit count: mostly small, sometimes zero, sometimes oversized.
  function automatic logic [7:0] random_hits();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) return 8'($urandom_range(255, 193));
    if (r < 14) return 8'd0;
    return 8'($urandom_range(4, 1));
  endfunction

  // Builds one packet and queues its bytes; hits below zero means random per event.
  task automatic make_packet(input logic [7:0] ver, input int n_events, input int hits,
                             input packet_end_e ending);
    logic [7:0]  q[$];
    logic [7:0]  n;
    bit          dropped;
    int unsigned cut;
    byte_item_t  it;
    dropped = 1'b0;
    for (int i = 0; i < 16; i++) q = {q, 8'($urandom)};
    q = {q, ver};
    q = {q, 8'($urandom)};
    if (ver >= VER_RUN16) q = {q, 8'($urandom)};
    for (int e = 0; e < n_events && !dropped; e++) begin
      n = (hits < 0) ? random_hits() : 8'(hits);
      q = {q, n};
      for (int i = 0; i < 11; i++) q = {q, 8'($urandom)};
      if (n > MAX_HITS) begin
        dropped = 1'b1;
        repeat ($urandom_range(4)) q = {q, 8'($urandom)};
      end else begin
        repeat (3 * int'(n)) q = {q, 8'($urandom)};
      end
    end
    if (ending == END_PAD) q = {q, PAD_BYTE};
    if (ending == END_CUT) begin
      cut = $urandom_range(q.size(), 1);
      while (q.size() > cut) void'(q.pop_back());
    end
    foreach (q[i]) begin
      it.data = q[i];
      it.eop = (i == q.size() - 1);
      pending_bytes = {pending_bytes, it};
    end
    packet_count++;
  endtask

  // Queues a run of random bytes with end marks scattered through it.
  task automatic make_noise(input int unsigned len);
    byte_item_t it;
    for (int unsigned i = 0; i < len; i++) begin
      it.data = 8'($urandom);
      it.eop = (i == len - 1) || ($urandom_range(9) == 0);
      if (it.eop) packet_count++;
      pending_bytes = {pending_bytes, it};
    end
  endtask

  // Driver: presents queued bytes and predicts each one as it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin : drive_bytes
    byte_item_t it;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      data_byte <= 8'h00;
      end_of_packet <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        parse_byte(data_byte, end_of_packet);
        accepted_bytes++;
      end
      if (!in_valid || in_ready_o) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          it = pending_bytes.pop_front();
          in_valid <= 1'b1;
          data_byte <= it.data;
          end_of_packet <= it.eop;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Monitor: takes records with random back-pressure and checks them in order.
  always @(posedge clk_i or negedge rst_ni) begin : check_records
    record_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        kind_count[record_kind_o]++;
        if (expected_records.size() == 0) begin
          errors++;
          $display("%0t: unexpected record, expected none, actual kind %0d word_a %0h",
                   $time, record_kind_o, word_a_o);
        end else begin
          want = expected_records.pop_front();
          check_field("record_kind", 48'(want.kind), 48'(record_kind_o));
          check_field("word_a", 48'(want.word_a), 48'(word_a_o));
          check_field("word_b", 48'(want.word_b), 48'(word_b_o));
          check_field("word_c", 48'(want.word_c), 48'(word_c_o));
          check_field("word_d", 48'(want.word_d), 48'(word_d_o));
          check_field("small_a", 48'(want.small_a), 48'(small_a_o));
          check_field("small_b", 48'(want.small_b), 48'(small_b_o));
          check_field("format_version", 48'(want.format_version), 48'(format_version_o));
          check_field("run_number", 48'(want.run_number), 48'(run_number_o));
          check_field("event_number", 48'(want.event_number), 48'(event_number_o));
          check_field("time_value", want.time_value, time_value_o);
          check_field("last_of_packet", 48'(want.last_of_packet), 48'(last_of_packet_o));
        end
      end
      out_ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  // Stimulus, reset and end of run.
  initial begin : run_test
    packet_end_e ending;
    int unsigned r;
    logic [7:0]  ver;

    // Directed packets: old and new run ids, hitless event, pad byte on both
    // sides of version 4, oversized hit counts and the largest parsed count.
    make_packet(8'd3, 0, 0, END_CLEAN);
    make_packet(8'd5, 1, 0, END_CLEAN);
    make_packet(8'd4, 1, 1, END_PAD);
    make_packet(8'd2, 1, 1, END_PAD);
    make_packet(8'd255, 1, 255, END_CLEAN);
    make_packet(8'd5, 2, 193, END_CLEAN);
    make_packet(8'd6, 2, -1, END_CUT);
    make_noise(3);
    make_packet(8'd5, 1, int'(MAX_HITS), END_CLEAN);

    // Random packets, mostly well formed, with noise and truncated ones mixed in.
    while (pending_bytes.size() < 1480) begin
      r = $urandom_range(99);
      if (r < 10) begin
        make_noise($urandom_range(30, 1));
      end else begin
        ver = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
        r = $urandom_range(99);
        ending = (r < 50) ? END_CLEAN : (r < 65) ? END_PAD : END_CUT;
        make_packet(ver, $urandom_range(3), -1, ending);
      end
    end
    total_bytes = pending_bytes.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_bytes < total_bytes || expected_records.size() != 0)
      @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("Covered %0d packets in %0d bytes under three back-pressure mixes.",
             packet_count, total_bytes);
    $display("Records seen: %0d header, %0d event, %0d hit, %0d status; %0d errors.",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3], errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #5_000_000;
    $display("Timeout with %0d of %0d bytes accepted and %0d records outstanding.",
             accepted_bytes, total_bytes, expected_records.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
